// ----- rtl/opkd_pkg.sv -----
// ----------------------------------------------------------------------------
// opkd_pkg
// Shared types and codes for the order-preserving key decoder.
// ----------------------------------------------------------------------------
package opkd_pkg;

  // Configuration limits and field widths
  localparam int MAX_COLUMNS  = 16;
  localparam int COL_TYPE_W   = 3;
  localparam int COL_CNT_W    = 5;   // column_count register / column counter
  localparam int COL_IDX_W    = 4;   // column_index result field
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = MAX_COLUMNS * COL_TYPE_W;
  localparam int FIELD_CNT_W  = 5;
  localparam int VALUE_W      = 64;
  localparam int KIND_W       = 3;
  localparam int STATUS_W     = 3;
  localparam int PHASE_W      = 3;

  // Numeric payload lengths in bytes
  localparam logic [FIELD_CNT_W-1:0] NUM_BYTES  = 5'd8;
  localparam logic [FIELD_CNT_W-1:0] UUID_BYTES = 5'd16;

  localparam logic [VALUE_W-1:0] SIGN_FLIP = 64'h8000_0000_0000_0000;

  // Key bytes with a meaning of their own
  localparam logic [7:0] TAG_NULL    = 8'h00;
  localparam logic [7:0] TAG_PRESENT = 8'h01;
  localparam logic [7:0] ESC_BYTE    = 8'hFF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_TYPES = 1'b1;

  // Column type codes (configuration)
  localparam logic [COL_TYPE_W-1:0] TY_INT       = 3'd0;
  localparam logic [COL_TYPE_W-1:0] TY_DECIMAL   = 3'd1;
  localparam logic [COL_TYPE_W-1:0] TY_TIMESTAMP = 3'd2;
  localparam logic [COL_TYPE_W-1:0] TY_BOOL      = 3'd3;
  localparam logic [COL_TYPE_W-1:0] TY_UUID      = 3'd4;
  localparam logic [COL_TYPE_W-1:0] TY_TEXT      = 3'd5;
  localparam logic [COL_TYPE_W-1:0] TY_BLOB      = 3'd6;
  localparam logic [COL_TYPE_W-1:0] TY_BLOB_ALT  = 3'd7;

  // Value kinds (results)
  localparam logic [KIND_W-1:0] KIND_NULL      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INT       = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DECIMAL   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TIMESTAMP = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BOOL      = 3'd4;
  localparam logic [KIND_W-1:0] KIND_UUID      = 3'd5;
  localparam logic [KIND_W-1:0] KIND_TEXT      = 3'd6;
  localparam logic [KIND_W-1:0] KIND_BLOB      = 3'd7;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_SHORT    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_TAG      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNTERMINATED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_ESCAPE   = 3'd4;

  // Decoder phases
  localparam logic [PHASE_W-1:0] PH_TAG  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_NUM  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_BOOL = 3'd2;
  localparam logic [PHASE_W-1:0] PH_UUID = 3'd3;
  localparam logic [PHASE_W-1:0] PH_STR  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_ESC  = 3'd5;
  localparam logic [PHASE_W-1:0] PH_DONE = 3'd6;

  typedef logic [MAX_COLUMNS-1:0][COL_TYPE_W-1:0] col_types_t;

  // One result item
  typedef struct packed {
    logic [COL_IDX_W-1:0]       column_index;
    logic [KIND_W-1:0]          value_kind;
    logic                       has_data;
    logic signed [VALUE_W-1:0]  value;
    logic                       piece_last;
    logic                       key_done;
    logic [STATUS_W-1:0]        status;
  } result_t;

endpackage

// ----- rtl/order_preserving_key_decoder_top.sv -----
// ----------------------------------------------------------------------------
// order_preserving_key_decoder_top
// Streams an order-preserving encoded key one byte per transfer and returns
// decoded column values, data bytes and error status.
// ----------------------------------------------------------------------------
// For each key byte, the decode state (phase, column, byte count,
// 64-bit shift accumulator) is updated in the cycle the byte is taken, and the
// result, if any, lands in a single output register. A new byte is taken every
// cycle while the result side is not stalling; when that register holds a
// result that is stalled, in_stall is raised. A result appears in the cycle
// after its byte is taken and holds while stalled. cfg_ready is always high
// and writes act at once; write only between keys. No clearing pass after reset.
module order_preserving_key_decoder_top
  import opkd_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  // key byte channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_key_byte,
  input  logic                         in_key_last,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [COL_IDX_W-1:0]         out_column_index,
  output logic [KIND_W-1:0]            out_value_kind,
  output logic                         out_has_data,
  output logic signed [VALUE_W-1:0]    out_value,
  output logic                         out_piece_last,
  output logic                         out_key_done,
  output logic [STATUS_W-1:0]          out_status,
  // configuration write port
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata
);

  // Configuration registers
  logic [COL_CNT_W-1:0]   col_count_r;
  col_types_t             col_types_r;

  // Decode state
  logic [PHASE_W-1:0]     phase_r,  phase_nxt;
  logic [COL_CNT_W-1:0]   col_r,    col_nxt;
  logic [FIELD_CNT_W-1:0] bif_r,    bif_nxt;
  logic [VALUE_W-1:0]     acc_r,    acc_nxt;
  logic                   err_r,    err_nxt;

  // Output register
  logic                   out_valid_r;
  result_t                res_r;

  // Decode signals
  result_t                res;
  logic                   res_vld;
  logic                   in_acc;
  logic                   finish;
  logic [STATUS_W-1:0]    err_code;
  logic [COL_CNT_W-1:0]   ncols;
  logic [COL_IDX_W-1:0]   col_idx;
  logic [COL_TYPE_W-1:0]  ctype;
  logic [KIND_W-1:0]      kind;
  logic [FIELD_CNT_W-1:0] bif_inc;
  logic [COL_CNT_W-1:0]   col_inc;
  logic [VALUE_W-1:0]     byte_ext;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      col_types_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COLUMN_COUNT: col_count_r <= cfg_wdata[COL_CNT_W-1:0];
        CFG_COLUMN_TYPES: col_types_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Column lookup
  assign ncols    = (col_count_r > COL_CNT_W'(MAX_COLUMNS)) ? COL_CNT_W'(MAX_COLUMNS)
                                                             : col_count_r;
  assign col_idx  = col_r[COL_IDX_W-1:0];
  assign ctype    = col_types_r[col_idx];
  assign kind     = (ctype == TY_BLOB_ALT) ? KIND_BLOB : KIND_W'(ctype + 3'd1);
  assign bif_inc  = FIELD_CNT_W'(bif_r + 5'd1);
  assign col_inc  = COL_CNT_W'(col_r + 5'd1);
  assign byte_ext = VALUE_W'(in_key_byte);

  // Per-byte decode
  always_comb begin
    phase_nxt = phase_r;
    col_nxt   = col_r;
    bif_nxt   = bif_r;
    acc_nxt   = acc_r;
    err_nxt   = err_r;
    res       = '0;
    res_vld   = 1'b0;
    finish    = 1'b0;
    err_code  = ST_OK;

    if (err_r || phase_r == PH_DONE) begin
      // skipping to end of key
    end else if (phase_r == PH_TAG && col_r >= ncols) begin
      // all columns decoded (or none configured)
      res.key_done = 1'b1;
      res_vld      = 1'b1;
      phase_nxt    = PH_DONE;
    end else begin
      res.column_index = col_idx;
      case (phase_r)
        PH_TAG: begin
          if (in_key_byte == TAG_NULL) begin
            res.piece_last = 1'b1;
            res_vld        = 1'b1;
            finish         = 1'b1;
          end else if (in_key_byte == TAG_PRESENT) begin
            bif_nxt = '0;
            acc_nxt = '0;
            if (ctype inside {TY_INT, TY_DECIMAL, TY_TIMESTAMP}) begin
              phase_nxt = PH_NUM;
            end else if (ctype == TY_BOOL) begin
              phase_nxt = PH_BOOL;
            end else if (ctype == TY_UUID) begin
              phase_nxt = PH_UUID;
            end else begin
              phase_nxt = PH_STR;
            end
          end else begin
            err_code = ST_BAD_TAG;
          end
        end
        PH_NUM: begin
          acc_nxt = {acc_r[VALUE_W-9:0], in_key_byte};
          bif_nxt = bif_inc;
          if (bif_inc >= NUM_BYTES) begin
            res.value_kind = kind;
            res.has_data   = 1'b1;
            res.value      = acc_nxt ^ SIGN_FLIP;
            res.piece_last = 1'b1;
            res_vld        = 1'b1;
            finish         = 1'b1;
          end
        end
        PH_BOOL: begin
          res.value_kind = kind;
          res.has_data   = 1'b1;
          res.value      = VALUE_W'(in_key_byte != 8'h00);
          res.piece_last = 1'b1;
          res_vld        = 1'b1;
          finish         = 1'b1;
        end
        PH_UUID: begin
          bif_nxt        = bif_inc;
          res.value_kind = kind;
          res.has_data   = 1'b1;
          res.value      = byte_ext;
          res.piece_last = (bif_inc >= UUID_BYTES);
          res_vld        = 1'b1;
          finish         = (bif_inc >= UUID_BYTES);
        end
        PH_STR: begin
          if (in_key_byte != 8'h00) begin
            res.value_kind = kind;
            res.has_data   = 1'b1;
            res.value      = byte_ext;
            res_vld        = 1'b1;
          end else begin
            phase_nxt = PH_ESC;
          end
        end
        PH_ESC: begin
          if (in_key_byte == 8'h00) begin
            // terminator
            res.value_kind = kind;
            res.piece_last = 1'b1;
            res_vld        = 1'b1;
            finish         = 1'b1;
          end else if (in_key_byte == ESC_BYTE) begin
            // escaped zero data byte
            res.value_kind = kind;
            res.has_data   = 1'b1;
            res_vld        = 1'b1;
            phase_nxt      = PH_STR;
          end else begin
            err_code = ST_BAD_ESCAPE;
          end
        end
        default: ;
      endcase

      // column complete
      if (finish) begin
        col_nxt   = col_inc;
        bif_nxt   = '0;
        phase_nxt = PH_TAG;
        if (col_inc >= ncols) begin
          res.key_done = 1'b1;
          phase_nxt    = PH_DONE;
        end
      end

      // error or truncated key replaces the result
      if (err_code != ST_OK) begin
        res              = '0;
        res.column_index = col_idx;
        res.status       = err_code;
        res_vld          = 1'b1;
        err_nxt          = 1'b1;
      end else if (in_key_last && phase_nxt != PH_DONE) begin
        res              = '0;
        res.column_index = col_idx;
        res.status       = (phase_nxt == PH_STR || phase_nxt == PH_ESC) ? ST_UNTERMINATED
                                                                        : ST_TOO_SHORT;
        res_vld          = 1'b1;
      end
    end

    // end of key restarts the decoder
    if (in_key_last) begin
      phase_nxt = PH_TAG;
      col_nxt   = '0;
      bif_nxt   = '0;
      acc_nxt   = '0;
      err_nxt   = 1'b0;
    end
  end

  // State update on each byte transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TAG;
      col_r   <= '0;
      bif_r   <= '0;
      acc_r   <= '0;
      err_r   <= 1'b0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      col_r   <= col_nxt;
      bif_r   <= bif_nxt;
      acc_r   <= acc_nxt;
      err_r   <= err_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= res_vld;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_vld) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_column_index = res_r.column_index;
  assign out_value_kind   = res_r.value_kind;
  assign out_has_data     = res_r.has_data;
  assign out_value        = res_r.value;
  assign out_piece_last   = res_r.piece_last;
  assign out_key_done     = res_r.key_done;
  assign out_status       = res_r.status;

endmodule

// ----- rtl/opkd_checker.sv -----
// ----------------------------------------------------------------------------
// opkd_checker
// Port-level checks for the order-preserving key decoder, bound to the top.
// ----------------------------------------------------------------------------
module opkd_checker
  import opkd_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [COL_IDX_W-1:0]       out_column_index,
  input logic [KIND_W-1:0]          out_value_kind,
  input logic                       out_has_data,
  input logic signed [VALUE_W-1:0]  out_value,
  input logic                       out_piece_last,
  input logic                       out_key_done,
  input logic [STATUS_W-1:0]        out_status
);

  // Stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) &&
      $stable(out_status) && $stable(out_column_index) && $stable(out_value_kind))
    else $error("stalled result changed");

  // Byte side only stalls behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no waiting result");

  // Error results carry only their column index and status
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
      out_value_kind == KIND_NULL && !out_has_data && !out_piece_last && !out_key_done)
    else $error("error result carries data");

  // No data means a zero value
  a_nodata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_data |-> out_value == '0)
    else $error("value set without data");

  // Boolean results are 0 or 1
  a_bool_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_value_kind == KIND_BOOL |-> out_value == 64'sd0 || out_value == 64'sd1)
    else $error("boolean out of range");

endmodule

bind order_preserving_key_decoder_top opkd_checker u_opkd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_column_index (out_column_index),
  .out_value_kind   (out_value_kind),
  .out_has_data     (out_has_data),
  .out_value        (out_value),
  .out_piece_last   (out_piece_last),
  .out_key_done     (out_key_done),
  .out_status       (out_status)
);

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for order_preserving_key_decoder_top. Key bytes go in
// one transfer at a time; a bit-accurate decoder model in the bench predicts
// every result. Results are checked field by field in order. The stimulus is
// a short directed part, then random keys (mostly well formed, some cut,
// corrupted or noise) over many column layouts, with random idling on both
// channels, a long result-side hold-off and a mid-key drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import opkd_pkg::*;

  typedef logic [7:0] byte_q_t[$];
  typedef enum int {KEY_CLEAN, KEY_CUT, KEY_BAD_TAG, KEY_BAD_ESC, KEY_NOISE} key_flaw_t;

  localparam int RANDOM_GOAL   = 750;   // key bytes sent before the no-idle part
  localparam int NO_IDLE_ITEMS = 150;   // key bytes sent with no idling at the end
  localparam int HOLD_CYCLES   = 60;

  // DUT connections
  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [7:0]                in_key_byte;
  logic                      in_key_last;
  logic                      out_valid;
  logic                      out_stall;
  logic [COL_IDX_W-1:0]      out_column_index;
  logic [KIND_W-1:0]         out_value_kind;
  logic                      out_has_data;
  logic signed [VALUE_W-1:0] out_value;
  logic                      out_piece_last;
  logic                      out_key_done;
  logic [STATUS_W-1:0]       out_status;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_wdata;

  // Decoder model state and its copy of the registers
  logic [PHASE_W-1:0]     dec_phase;
  logic [COL_CNT_W-1:0]   dec_col;
  logic [FIELD_CNT_W-1:0] dec_cnt;
  logic [VALUE_W-1:0]     dec_acc;
  logic                   dec_err;
  logic [COL_CNT_W-1:0]   cols_cfg;
  logic [CFG_DATA_W-1:0]  types_cfg;

  result_t pending_results[$];
  int      mismatch_count = 0;
  int      sent_items = 0;     // key bytes transferred so far
  bit      idle_on = 1'b1;
  int      hold_req = 0;

  order_preserving_key_decoder_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_key_byte      (in_key_byte),
    .in_key_last      (in_key_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_column_index (out_column_index),
    .out_value_kind   (out_value_kind),
    .out_has_data     (out_has_data),
    .out_value        (out_value),
    .out_piece_last   (out_piece_last),
    .out_key_done     (out_key_done),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model --

  function automatic void clear_decoder();
    dec_phase = PH_TAG;
    dec_col   = '0;
    dec_cnt   = '0;
    dec_acc   = '0;
    dec_err   = 1'b0;
  endfunction

  function automatic result_t piece(input logic [COL_IDX_W-1:0] col,
                                    input logic [KIND_W-1:0] kind, input logic has,
                                    input logic [VALUE_W-1:0] val, input logic plast);
    result_t r;
    r              = '0;
    r.column_index = col;
    r.value_kind   = kind;
    r.has_data     = has;
    r.value        = val;
    r.piece_last   = plast;
    return r;
  endfunction

  // Advances the model by one key byte; returns 1 when a result comes out.
  function automatic bit decode_key_byte(input logic [7:0] b, input logic lst,
                                         output result_t r);
    logic [COL_CNT_W-1:0]  ncols;
    logic [COL_IDX_W-1:0]  col;
    logic [COL_TYPE_W-1:0] ty;
    logic [KIND_W-1:0]     kind;
    logic [STATUS_W-1:0]   err;
    bit                    got;
    bit                    finish;
    r      = '0;
    got    = 1'b0;
    finish = 1'b0;
    err    = ST_OK;
    ncols  = (cols_cfg > 5'(MAX_COLUMNS)) ? 5'(MAX_COLUMNS) : cols_cfg;

    // after an error or the last column, bytes are dropped until key_last
    if (dec_err || dec_phase == PH_DONE) begin
      if (lst) clear_decoder();
      return 1'b0;
    end
    // no columns left at a tag: report completion on this byte
    if (dec_phase == PH_TAG && dec_col >= ncols) begin
      r.key_done = 1'b1;
      dec_phase  = PH_DONE;
      if (lst) clear_decoder();
      return 1'b1;
    end

    col  = dec_col[COL_IDX_W-1:0];
    ty   = types_cfg[COL_TYPE_W*col +: COL_TYPE_W];
    kind = (ty == TY_BLOB_ALT) ? KIND_BLOB : ty + 3'd1;

    case (dec_phase)
      PH_TAG: begin
        if (b == TAG_NULL) begin
          r      = piece(col, KIND_NULL, 1'b0, '0, 1'b1);
          got    = 1'b1;
          finish = 1'b1;
        end else if (b == TAG_PRESENT) begin
          dec_cnt = '0;
          dec_acc = '0;
          if (ty <= TY_TIMESTAMP) dec_phase = PH_NUM;
          else if (ty == TY_BOOL) dec_phase = PH_BOOL;
          else if (ty == TY_UUID) dec_phase = PH_UUID;
          else dec_phase = PH_STR;
        end else begin
          err = ST_BAD_TAG;
        end
      end
      PH_NUM: begin
        dec_acc = {dec_acc[VALUE_W-9:0], b};
        dec_cnt = dec_cnt + 5'd1;
        if (dec_cnt >= NUM_BYTES) begin
          r      = piece(col, kind, 1'b1, dec_acc ^ SIGN_FLIP, 1'b1);
          got    = 1'b1;
          finish = 1'b1;
        end
      end
      PH_BOOL: begin
        r      = piece(col, kind, 1'b1, (b != 8'h00) ? 64'd1 : 64'd0, 1'b1);
        got    = 1'b1;
        finish = 1'b1;
      end
      PH_UUID: begin
        dec_cnt = dec_cnt + 5'd1;
        r       = piece(col, kind, 1'b1, {56'd0, b}, dec_cnt >= UUID_BYTES);
        got     = 1'b1;
        finish  = (dec_cnt >= UUID_BYTES);
      end
      PH_STR: begin
        if (b != 8'h00) begin
          r   = piece(col, kind, 1'b1, {56'd0, b}, 1'b0);
          got = 1'b1;
        end else begin
          dec_phase = PH_ESC;
        end
      end
      default: begin
        // second byte of an escape pair
        if (b == 8'h00) begin
          r      = piece(col, kind, 1'b0, '0, 1'b1);
          got    = 1'b1;
          finish = 1'b1;
        end else if (b == ESC_BYTE) begin
          r         = piece(col, kind, 1'b1, '0, 1'b0);
          got       = 1'b1;
          dec_phase = PH_STR;
        end else begin
          err = ST_BAD_ESCAPE;
        end
      end
    endcase

    if (finish) begin
      dec_col   = dec_col + 5'd1;
      dec_cnt   = '0;
      dec_phase = PH_TAG;
      if (dec_col >= ncols) begin
        r.key_done = 1'b1;
        dec_phase  = PH_DONE;
      end
    end

    // errors and a truncated key replace whatever this byte gave
    if (err != ST_OK) begin
      r        = piece(col, KIND_NULL, 1'b0, '0, 1'b0);
      r.status = err;
      got      = 1'b1;
      dec_err  = 1'b1;
    end else if (lst && dec_phase != PH_DONE) begin
      r        = piece(col, KIND_NULL, 1'b0, '0, 1'b0);
      r.status = (dec_phase == PH_STR || dec_phase == PH_ESC) ? ST_UNTERMINATED : ST_TOO_SHORT;
      got      = 1'b1;
    end

    if (lst) clear_decoder();
    return got;
  endfunction

  // ------------------------------------------------------------- drivers --

  // One key byte transfer; valid stays up when the next byte follows at once.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    result_t r;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid    = 1'b1;
    in_key_byte = b;
    in_key_last = lst;
    do @(posedge clk); while (in_stall);
    sent_items++;
    if (decode_key_byte(b, lst, r)) pending_results.insert(pending_results.size(), r);
  endtask

  // Sends a key with key_last on its final byte; optionally drains mid-key.
  task automatic send_key(input byte_q_t kb, input int pause_at = -1);
    for (int i = 0; i < kb.size(); i++) begin
      if (i == pause_at) wait_drained();
      send_byte(kb[i], i == kb.size() - 1);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_COLUMN_COUNT) cols_cfg = data[COL_CNT_W-1:0];
    else types_cfg = data;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Registers change only once the decoder is idle; unused count bits are random.
  task automatic set_config(input logic [COL_CNT_W-1:0] cnt, input col_types_t ct);
    wait_drained();
    repeat (3) @(posedge clk);
    write_reg(CFG_COLUMN_COUNT, {11'($urandom), 32'($urandom)} << COL_CNT_W | 48'(cnt));
    write_reg(CFG_COLUMN_TYPES, ct);
  endtask

  // ------------------------------------------------------------ key build --

  // Adds one byte at the end of a key under construction
  function automatic void append_byte(ref byte_q_t q, input logic [7:0] b);
    q.insert(q.size(), b);
  endfunction

  function automatic key_flaw_t pick_flaw();
    case ($urandom_range(0, 19))
      0, 1:    return KEY_CUT;
      2, 3:    return KEY_BAD_TAG;
      4, 5:    return KEY_BAD_ESC;
      6:       return KEY_NOISE;
      default: return KEY_CLEAN;
    endcase
  endfunction

  // Encodes a key for the current layout with random content, then breaks it.
  function automatic byte_q_t make_key(input key_flaw_t flaw);
    byte_q_t               kb;
    int                    tag_at[$];
    int                    esc_at[$];
    int                    ncols;
    int                    pick;
    int                    pos;
    logic [COL_TYPE_W-1:0] ty;
    ncols = (cols_cfg > 5'(MAX_COLUMNS)) ? MAX_COLUMNS : int'(cols_cfg);
    for (int c = 0; c < ncols; c++) begin
      ty = types_cfg[COL_TYPE_W*c +: COL_TYPE_W];
      tag_at.insert(tag_at.size(), kb.size());
      if ($urandom_range(0, 4) == 0) begin
        append_byte(kb, TAG_NULL);
        continue;
      end
      append_byte(kb, TAG_PRESENT);
      if (ty <= TY_TIMESTAMP) begin
        // extremes of the 64-bit range, zero, or random
        pick = $urandom_range(0, 3);
        for (int i = 0; i < 8; i++)
          case (pick)
            0:       append_byte(kb, 8'h00);
            1:       append_byte(kb, 8'hFF);
            2:       append_byte(kb, (i == 0) ? 8'h80 : 8'h00);
            default: append_byte(kb, 8'($urandom));
          endcase
      end else if (ty == TY_BOOL) begin
        append_byte(kb, ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1)));
      end else if (ty == TY_UUID) begin
        repeat (16) append_byte(kb, 8'($urandom));
      end else begin
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(0, 3) == 0) begin
            esc_at.insert(esc_at.size(), kb.size());
            append_byte(kb, 8'h00);
            append_byte(kb, ESC_BYTE);
          end else begin
            append_byte(kb, 8'($urandom_range(1, 255)));
          end
        end
        esc_at.insert(esc_at.size(), kb.size());
        append_byte(kb, 8'h00);
        append_byte(kb, 8'h00);
      end
    end
    if (kb.size() == 0) append_byte(kb, 8'($urandom));

    case (flaw)
      KEY_CUT: begin
        pos = $urandom_range(1, kb.size());
        while (kb.size() > pos) void'(kb.pop_back());
      end
      KEY_BAD_TAG: begin
        if (tag_at.size() != 0) kb[tag_at[$urandom_range(0, tag_at.size() - 1)]] =
          8'($urandom_range(2, 255));
      end
      KEY_BAD_ESC: begin
        if (esc_at.size() != 0) kb[esc_at[$urandom_range(0, esc_at.size() - 1)] + 1] =
          8'($urandom_range(1, 254));
      end
      KEY_NOISE: begin
        kb.delete();
        repeat ($urandom_range(1, 8)) append_byte(kb, 8'($urandom));
      end
      default: begin
        // trailing bytes after the last column
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3)) append_byte(kb, 8'($urandom));
      end
    endcase
    return kb;
  endfunction

  // ---------------------------------------------------------------- tests --

  task automatic test_directed();
    col_types_t ct;
    byte_q_t    kb;
    // zero columns: first byte completes the key
    set_config(5'd0, '0);
    kb = '{8'hFF};
    send_key(kb);
    // bool, text, and a column of type code 7 (blob)
    ct    = '0;
    ct[0] = TY_BOOL;
    ct[1] = TY_TEXT;
    ct[2] = TY_BLOB_ALT;
    set_config(5'd3, ct);
    // null, escaped zero byte, empty blob, trailing byte
    kb = '{8'h00, 8'h01, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h7F};
    send_key(kb);
    // true bool, then text cut off inside its data
    kb = '{8'h01, 8'hFF, 8'h01, 8'h42};
    send_key(kb);
    // bad tag, following byte dropped
    kb = '{8'h05, 8'h00};
    send_key(kb);
    // bad escape inside text
    kb = '{8'h00, 8'h01, 8'h00, 8'h07};
    send_key(kb);
    // count above the maximum, all integers: largest value, then key too short
    set_config(5'd31, '0);
    kb = '{8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
    send_key(kb);
  endtask

  // Result side holds off while UUID bytes keep coming, so the input stalls.
  task automatic test_backpressure();
    col_types_t ct;
    byte_q_t    kb;
    ct    = '0;
    ct[0] = TY_UUID;
    set_config(5'd1, ct);
    append_byte(kb, TAG_PRESENT);
    repeat (16) append_byte(kb, 8'($urandom));
    hold_req = HOLD_CYCLES;
    send_key(kb);
    send_key(kb);
  endtask

  // Sender stops in the middle of a key until every result is back.
  task automatic test_drain_pause();
    col_types_t ct;
    byte_q_t    kb;
    ct    = '0;
    ct[0] = TY_DECIMAL;
    ct[1] = TY_TEXT;
    set_config(5'd2, ct);
    kb = make_key(KEY_CLEAN);
    send_key(kb, kb.size() / 2);
  endtask

  task automatic test_random_keys(input int item_goal);
    col_types_t           ct;
    logic [COL_CNT_W-1:0] cnt;
    int                   keys;
    while (sent_items < item_goal) begin
      ct = col_types_t'({16'($urandom), 32'($urandom)});
      case ($urandom_range(0, 11))
        0:       cnt = 5'd0;
        1:       cnt = 5'(MAX_COLUMNS);
        2:       cnt = 5'($urandom_range(17, 31));
        3: begin
          cnt = 5'($urandom_range(1, 4));
          ct  = '1;
        end
        4: begin
          cnt = 5'($urandom_range(1, 4));
          ct  = '0;
        end
        default: cnt = 5'($urandom_range(1, 5));
      endcase
      set_config(cnt, ct);
      keys = (cnt > 5'd5) ? 2 : $urandom_range(4, 12);
      repeat (keys) send_key(make_key(pick_flaw()));
    end
  endtask

  // Closing stretch with no idling on either side
  task automatic test_no_idle();
    idle_on = 1'b0;
    test_random_keys(sent_items + NO_IDLE_ITEMS);
  endtask

  // -------------------------------------------------------- result side --

  // Result stall: random bursts, or a long hold-off when one is requested
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall  = 1'b1;
        stall_left = $urandom_range(0, 12);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("result with none predicted: column %0d status %0d",
               out_column_index, out_status);
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("column_index", 64'(exp_r.column_index), 64'(out_column_index));
        check_field("value_kind", 64'(exp_r.value_kind), 64'(out_value_kind));
        check_field("has_data", 64'(exp_r.has_data), 64'(out_has_data));
        check_field("value", exp_r.value, out_value);
        check_field("piece_last", 64'(exp_r.piece_last), 64'(out_piece_last));
        check_field("key_done", 64'(exp_r.key_done), 64'(out_key_done));
        check_field("status", 64'(exp_r.status), 64'(out_status));
      end
    end
  end

  // ----------------------------------------------------------------- main --

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_key_byte = '0;
    in_key_last = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_COLUMN_COUNT;
    cfg_wdata   = '0;
    cols_cfg    = '0;
    types_cfg   = '0;
    clear_decoder();
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_backpressure();
    test_drain_pause();
    test_random_keys(RANDOM_GOAL);
    test_no_idle();

    wait_drained();
    repeat (5) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/opkd_pkg.sv
rtl/order_preserving_key_decoder_top.sv
rtl/opkd_checker.sv
tb/sv/tb.sv
